// ===== rtl/core/evr_pkg.sv =====
package evr_pkg;

    // sine and cosine are Q2.30 values, 1.0 = 2^30
    localparam int TRIG_BITS = 30;
    localparam logic [31:0] TRIG_ONE = 32'h4000_0000;

    // angles in 1/64 degree
    localparam int QUARTER   = 5760;
    localparam int FULL_TURN = 23040;

    // pi/11520 in Q30
    localparam logic [31:0] RAD_PER_UNIT = 32'd292818;

    // Taylor terms evaluated in Horner form
    localparam int TERMS = 5;

    typedef enum logic [1:0] {
        REG_ANGLE_X = 2'd0,
        REG_ANGLE_Y = 2'd1,
        REG_ANGLE_Z = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        TRIG_IDLE,
        TRIG_ARG,
        TRIG_X,
        TRIG_X2,
        TRIG_P,
        TRIG_T,
        TRIG_Q,
        TRIG_S
    } trig_state_t;

    // sine and cosine of the three angles
    typedef struct packed {
        logic signed [31:0] sin_x;
        logic signed [31:0] cos_x;
        logic signed [31:0] sin_y;
        logic signed [31:0] cos_y;
        logic signed [31:0] sin_z;
        logic signed [31:0] cos_z;
    } trig_t;

    // divisor of each Horner step
    function automatic logic [6:0] term_div(input logic [2:0] i);
        logic [6:0] d;
        case (i)
            3'd0:    d = 7'd110;
            3'd1:    d = 7'd72;
            3'd2:    d = 7'd42;
            3'd3:    d = 7'd20;
            3'd4:    d = 7'd6;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor), quotient is then short by at most one
    function automatic logic [31:0] term_recip(input logic [2:0] i);
        logic [31:0] m;
        case (i)
            3'd0:    m = 32'd39045157;
            3'd1:    m = 32'd59652323;
            3'd2:    m = 32'd102261126;
            3'd3:    m = 32'd214748364;
            3'd4:    m = 32'd715827882;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/euler_xyz_vector_rotate.sv =====
// rotates each Q16.16 vector (s_vec_x, s_vec_y, s_vec_z) about X, then Y, then Z by the
// angles held in config registers 0..2 (angle_x, angle_y, angle_z, signed, 1/64 degree,
// any value wraps modulo 360 degrees); each component saturates after every rotation.
// throughput is one vector per cycle unless a sweep runs or m_ready is low; each axis
// rotation is a product stage of four 32x32 multipliers followed by a sum, round-half-up
// and saturate stage. after reset and after every angle write the sine and cosine of all
// three angles are recomputed by a shared multiplier running an eleventh-order Taylor
// series, and s_ready stays low until the sweep is done. configuration transfers are
// always taken; write angles only while idle
module euler_xyz_vector_rotate (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_vec_x,
    input  logic signed [31:0] s_vec_y,
    input  logic signed [31:0] s_vec_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic signed [31:0] m_out_z
);
    import evr_pkg::*;

    trig_t trig;
    logic  busy;
    logic  rx_ready;
    logic  vx_valid, vx_ready, vy_valid, vy_ready;
    logic signed [31:0] xa_y, xa_z, xa_x;
    logic signed [31:0] ya_x, ya_z, ya_y;
    logic signed [31:0] neg_sin_z;

    // sine and cosine sequencer plus the angle registers
    evr_trig u_trig (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .trig      (trig)
    );

    // no transfer in while the trig values are being rebuilt
    assign s_ready = rx_ready && !busy;

    // about X: y' = y c + z s, z' = z c - y s
    evr_rot u_rot_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && !busy),
        .in_ready  (rx_ready),
        .in_p      (s_vec_y),
        .in_q      (s_vec_z),
        .in_r      (s_vec_x),
        .c         (trig.cos_x),
        .s         (trig.sin_x),
        .out_valid (vx_valid),
        .out_ready (vx_ready),
        .out_p     (xa_y),
        .out_q     (xa_z),
        .out_r     (xa_x)
    );

    // about Y: x' = x c + z s, z' = z c - x s
    evr_rot u_rot_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vx_valid),
        .in_ready  (vx_ready),
        .in_p      (xa_x),
        .in_q      (xa_z),
        .in_r      (xa_y),
        .c         (trig.cos_y),
        .s         (trig.sin_y),
        .out_valid (vy_valid),
        .out_ready (vy_ready),
        .out_p     (ya_x),
        .out_q     (ya_z),
        .out_r     (ya_y)
    );

    // about Z the sine enters negated: x' = x c - y s, y' = y c + x s
    assign neg_sin_z = -trig.sin_z;

    evr_rot u_rot_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vy_valid),
        .in_ready  (vy_ready),
        .in_p      (ya_x),
        .in_q      (ya_y),
        .in_r      (ya_z),
        .c         (trig.cos_z),
        .s         (neg_sin_z),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_p     (m_out_x),
        .out_q     (m_out_y),
        .out_r     (m_out_z)
    );

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !busy)
        else $error("vector taken during trig rebuild");

endmodule

// ===== rtl/core/evr_trig.sv =====
module evr_trig (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output logic              busy,
    output evr_pkg::trig_t    trig
);
    import evr_pkg::*;

    trig_state_t state_reg, state_next;
    logic signed [15:0] angle_reg [3];
    logic [2:0]  job_reg, job_next;
    logic [2:0]  iter_reg, iter_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] x2_reg, x2_next;
    logic [31:0] p_reg, p_next;
    logic [31:0] t_reg, t_next;
    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    logic [31:0] mul_a, mul_b;
    logic signed [31:0] sin_reg [3];
    logic signed [31:0] cos_reg [3];

    logic              cfg_wr;
    logic signed [15:0] angle_sel;
    logic signed [17:0] a_ext, r_a;
    logic [15:0] r_c, off;
    logic [1:0]  quad;
    logic [12:0] f;
    logic        neg;
    logic        trivial;
    logic        last_job;
    logic [31:0] q_est, q_fix, t_new, s_raw;
    logic [39:0] rem;
    logic        store_en;
    logic [31:0] store_mag;
    logic signed [31:0] store_val;

    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y
                                  || cfg_index == REG_ANGLE_Z);
    assign busy = (state_reg != TRIG_IDLE);
    assign last_job = (job_reg == 3'd5);

    // angle reduction and quadrant split of the current job
    always_comb begin
        angle_sel = angle_reg[job_reg[2:1]];
        a_ext = {{2{angle_sel[15]}}, angle_sel};
        r_a = a_ext;
        if (a_ext < 18'sd0) begin
            r_a = a_ext + 18'sd23040;
            if (r_a < 18'sd0) begin
                r_a = r_a + 18'sd23040;
            end
        end else if (a_ext >= 18'sd23040) begin
            r_a = a_ext - 18'sd23040;
        end
        r_c = {1'b0, r_a[14:0]} + (job_reg[0] ? 16'(QUARTER) : 16'd0);
        if (r_c >= 16'(FULL_TURN)) begin
            r_c = r_c - 16'(FULL_TURN);
        end
        if (r_c >= 16'(3 * QUARTER)) begin
            quad = 2'd3;
            off = r_c - 16'(3 * QUARTER);
        end else if (r_c >= 16'(2 * QUARTER)) begin
            quad = 2'd2;
            off = r_c - 16'(2 * QUARTER);
        end else if (r_c >= 16'(QUARTER)) begin
            quad = 2'd1;
            off = r_c - 16'(QUARTER);
        end else begin
            quad = 2'd0;
            off = r_c;
        end
        f = quad[0] ? 13'(QUARTER) - off[12:0] : off[12:0];
        neg = quad[1];
        trivial = (f == 13'd0) || (f == 13'(QUARTER));
    end

    // reciprocal quotient with one correction step
    always_comb begin
        q_est = prod_reg[63:32];
        rem = {8'd0, p_reg} - (40'(q_est) * 40'(term_div(iter_reg)));
        q_fix = q_est + ((rem >= 40'(term_div(iter_reg))) ? 32'd1 : 32'd0);
        t_new = TRIG_ONE - q_fix;
        s_raw = prod_reg[61:30];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            TRIG_IDLE: state_next = TRIG_IDLE;
            TRIG_ARG: begin
                if (trivial) begin
                    state_next = last_job ? TRIG_IDLE : TRIG_ARG;
                end else begin
                    state_next = TRIG_X;
                end
            end
            TRIG_X:  state_next = TRIG_X2;
            TRIG_X2: state_next = TRIG_P;
            TRIG_P:  state_next = TRIG_T;
            TRIG_T:  state_next = TRIG_Q;
            TRIG_Q:  state_next = (iter_reg == 3'(TERMS - 1)) ? TRIG_S : TRIG_P;
            TRIG_S:  state_next = last_job ? TRIG_IDLE : TRIG_ARG;
            default: state_next = TRIG_IDLE;
        endcase
        if (cfg_wr) begin
            state_next = TRIG_ARG;
        end
    end

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        iter_next = iter_reg;
        x_next = x_reg;
        x2_next = x2_reg;
        p_next = p_reg;
        t_next = t_reg;
        store_en = 1'b0;
        store_mag = 32'd0;
        case (state_reg)
            TRIG_ARG: begin
                if (trivial) begin
                    store_en = 1'b1;
                    store_mag = (f == 13'd0) ? 32'd0 : TRIG_ONE;
                end else begin
                    mul_a = 32'(f);
                    mul_b = RAD_PER_UNIT;
                end
            end
            TRIG_X: begin
                x_next = prod_reg[31:0];
                mul_a = prod_reg[31:0];
                mul_b = prod_reg[31:0];
            end
            TRIG_X2: begin
                // first step uses t = 1.0
                x2_next = prod_reg[61:30];
                iter_next = 3'd0;
                mul_a = prod_reg[61:30];
                mul_b = TRIG_ONE;
            end
            TRIG_P: begin
                p_next = prod_reg[61:30];
                mul_a = prod_reg[61:30];
                mul_b = term_recip(iter_reg);
            end
            TRIG_T: begin
                // quotient settles here, product issued next cycle
                t_next = t_new;
            end
            TRIG_Q: begin
                iter_next = iter_reg + 3'd1;
                mul_a = (iter_reg == 3'(TERMS - 1)) ? x_reg : x2_reg;
                mul_b = t_reg;
            end
            TRIG_S: begin
                store_en = 1'b1;
                store_mag = (s_raw > TRIG_ONE) ? TRIG_ONE : s_raw;
            end
            default: begin
                store_en = 1'b0;
            end
        endcase
        store_val = neg ? -$signed(store_mag) : $signed(store_mag);
        job_next = job_reg;
        if (store_en) begin
            job_next = last_job ? 3'd0 : job_reg + 3'd1;
        end
        if (cfg_wr) begin
            job_next = 3'd0;
        end
        prod_next = mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TRIG_ARG;
            job_reg <= 3'd0;
            iter_reg <= 3'd0;
            for (int i = 0; i < 3; i++) begin
                angle_reg[i] <= 16'sd0;
            end
        end else begin
            state_reg <= state_next;
            job_reg <= job_next;
            iter_reg <= iter_next;
            if (cfg_wr) begin
                angle_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        x2_reg <= x2_next;
        p_reg <= p_next;
        t_reg <= t_next;
        prod_reg <= prod_next;
        if (store_en && !cfg_wr) begin
            if (job_reg[0]) begin
                cos_reg[job_reg[2:1]] <= store_val;
            end else begin
                sin_reg[job_reg[2:1]] <= store_val;
            end
        end
    end

    assign trig.sin_x = sin_reg[0];
    assign trig.cos_x = cos_reg[0];
    assign trig.sin_y = sin_reg[1];
    assign trig.cos_y = cos_reg[1];
    assign trig.sin_z = sin_reg[2];
    assign trig.cos_z = cos_reg[2];

    a_iter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= 3'(TERMS))
        else $error("horner step count out of range");

    a_s_after_q: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == TRIG_S |-> $past(state_reg) == TRIG_Q)
        else $error("final product without last horner step");

    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        store_en |-> store_mag <= TRIG_ONE)
        else $error("trig magnitude above one");

endmodule

// ===== rtl/core/evr_rot.sv =====
module evr_rot (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] in_p,
    input  logic signed [31:0] in_q,
    input  logic signed [31:0] in_r,
    input  logic signed [31:0] c,
    input  logic signed [31:0] s,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_p,
    output logic signed [31:0] out_q,
    output logic signed [31:0] out_r
);
    import evr_pkg::*;

    logic v1_reg, v2_reg;
    logic en1, en2;
    logic signed [63:0] pc_reg, qs_reg, qc_reg, ps_reg;
    logic signed [31:0] r1_reg;
    logic signed [31:0] p2_reg, q2_reg, r2_reg;
    logic signed [31:0] p_next, q_next;

    // floor((v + 2^29) / 2^30) clipped to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] v);
        logic signed [63:0] w;
        logic signed [33:0] sh;
        logic signed [31:0] r;
        w = v + (64'sd1 <<< (TRIG_BITS - 1));
        sh = 34'(w >>> TRIG_BITS);
        if (sh > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (sh < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = sh[31:0];
        end
        return r;
    endfunction

    assign en2 = !v2_reg || out_ready;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;
    assign out_valid = v2_reg;
    assign out_p = p2_reg;
    assign out_q = q2_reg;
    assign out_r = r2_reg;

    assign p_next = round_sat(pc_reg + qs_reg);
    assign q_next = round_sat(qc_reg - ps_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            pc_reg <= in_p * c;
            qs_reg <= in_q * s;
            qc_reg <= in_q * c;
            ps_reg <= in_p * s;
            r1_reg <= in_r;
        end
        if (en2 && v1_reg) begin
            p2_reg <= p_next;
            q2_reg <= q_next;
            r2_reg <= r1_reg;
        end
    end

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> v1_reg)
        else $error("accepted item lost in product stage");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && en2 |=> v2_reg)
        else $error("product stage item lost in sum stage");

endmodule

// ===== verif/tb_euler_xyz_vector_rotate.sv =====
module tb_euler_xyz_vector_rotate;
    timeunit 1ns;
    timeprecision 1ps;
    import evr_pkg::*;

    // index past angle_z, the block ignores it
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int RAND_PHASES = 8;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_vec_x = '0;
    logic signed [31:0] s_vec_y = '0;
    logic signed [31:0] s_vec_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_out_x;
    logic signed [31:0] m_out_y;
    logic signed [31:0] m_out_z;

    euler_xyz_vector_rotate dut (.*);

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor copy of the angle registers
    logic [15:0] angle_reg [3];

    vec_t vec_q[$];      // vectors waiting to be driven
    vec_t rotated_q[$];  // predicted rotated vectors
    int   errors = 0;
    bit   no_gaps = 1'b0;

    // sine magnitude of f in [0, QUARTER], Q30, truncating Horner series
    function automatic longint unsigned quarter_sine(int unsigned f);
        longint unsigned one, x, x2, t;
        one = 64'd1 << TRIG_BITS;
        if (f == 0) return 0;
        if (f >= QUARTER) return one;
        x  = longint'(f) * longint'(RAD_PER_UNIT);
        x2 = (x * x) >> TRIG_BITS;
        t = one - x2 / 110;
        t = one - ((x2 * t) >> TRIG_BITS) / 72;
        t = one - ((x2 * t) >> TRIG_BITS) / 42;
        t = one - ((x2 * t) >> TRIG_BITS) / 20;
        t = one - ((x2 * t) >> TRIG_BITS) / 6;
        t = (x * t) >> TRIG_BITS;
        return (t > one) ? one : t;
    endfunction

    // signed Q30 sine of r in [0, FULL_TURN)
    function automatic longint signed_sine(int unsigned r);
        int unsigned quad, f;
        longint m;
        quad = r / QUARTER;
        f    = r % QUARTER;
        m = (quad & 1) ? longint'(quarter_sine(QUARTER - f)) : longint'(quarter_sine(f));
        return (quad & 2) ? -m : m;
    endfunction

    function automatic void angle_trig(logic [15:0] a, output longint c, output longint s);
        int r;
        r = int'(signed'(a)) % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        s = signed_sine(r);
        c = signed_sine((r + QUARTER) % FULL_TURN);
    endfunction

    // round half up out of Q30, then clamp to 32 bits
    function automatic longint round_clamp(longint v);
        longint r;
        r = (v + (64'sd1 <<< (TRIG_BITS - 1))) >>> TRIG_BITS;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    // p' = p*c + q*s, q' = q*c - p*s
    function automatic void turn_pair(inout longint p, inout longint q,
                                      input longint c, input longint s);
        longint np, nq;
        np = round_clamp(p * c + q * s);
        nq = round_clamp(q * c - p * s);
        p = np;
        q = nq;
    endfunction

    function automatic vec_t rotate_vec(vec_t v);
        longint x, y, z, c, s;
        vec_t o;
        x = v.x;
        y = v.y;
        z = v.z;
        if (angle_reg[REG_ANGLE_X] != 0) begin
            angle_trig(angle_reg[REG_ANGLE_X], c, s);
            turn_pair(y, z, c, s);
        end
        if (angle_reg[REG_ANGLE_Y] != 0) begin
            angle_trig(angle_reg[REG_ANGLE_Y], c, s);
            turn_pair(x, z, c, s);
        end
        if (angle_reg[REG_ANGLE_Z] != 0) begin
            angle_trig(angle_reg[REG_ANGLE_Z], c, s);
            turn_pair(x, y, c, -s);
        end
        o.x = x[31:0];
        o.y = y[31:0];
        o.z = z[31:0];
        return o;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mix of full-range, small and corner components
    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2, 3: return $signed($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
            4: return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
        endcase
    endfunction

    // ---------------- input driver ----------------
    bit in_took = 1'b0;
    int in_gap = 0;

    always @(negedge aclk) begin
        vec_t v;
        if (aresetn && (!s_valid || in_took)) begin
            if (in_gap > 0) begin
                in_gap--;
                s_valid <= 1'b0;
            end else if (vec_q.size() > 0) begin
                v = vec_q.pop_front();
                s_valid <= 1'b1;
                s_vec_x <= v.x;
                s_vec_y <= v.y;
                s_vec_z <= v.z;
                in_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- result stall generator ----------------
    int out_stall = 0;

    always @(negedge aclk) begin
        if (out_stall > 0) begin
            out_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            out_stall = pick_gap();
        end
    end

    // ---------------- monitor, checker and watchdog ----------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        vec_t got, want;
        in_took = s_valid && s_ready;
        if (aresetn) begin
            // predict on every accepted input transfer
            if (s_valid && s_ready) begin
                got.x = s_vec_x;
                got.y = s_vec_y;
                got.z = s_vec_z;
                rotated_q.push_back(rotate_vec(got));
            end
            if (m_valid && m_ready) begin
                got.x = m_out_x;
                got.y = m_out_y;
                got.z = m_out_z;
                if (rotated_q.size() == 0) begin
                    $display("%0t: unexpected result x=%h y=%h z=%h",
                             $time, got.x, got.y, got.z);
                    errors++;
                end else begin
                    want = rotated_q.pop_front();
                    if (got.x !== want.x) begin
                        $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
                        errors++;
                    end
                    if (got.y !== want.y) begin
                        $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
                        errors++;
                    end
                    if (got.z !== want.z) begin
                        $display("%0t: out_z expected %h actual %h", $time, want.z, got.z);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog, no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("** euler_xyz_vector_rotate: FAILED **");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    // waits until every vector is driven and every result has come back
    task automatic wait_drained();
        do @(posedge aclk);
        while (vec_q.size() > 0 || s_valid || rotated_q.size() > 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_angle(logic [1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        if (idx != REG_UNUSED) angle_reg[idx] = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_vec(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
        vec_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        vec_q.push_back(v);
    endtask

    // corner and random angles, including wrap beyond a full turn and the 16-bit extremes
    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd23040;
            2: return -16'sd23040;
            3: return 16'h7fff;
            4: return 16'h8000;
            5: return 16'(QUARTER * $urandom_range(1, 3));
            6: return $urandom;
            default: return 16'($signed($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    task automatic push_corners();
        push_vec(0, 0, 0);
        push_vec(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        push_vec(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        push_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        push_vec(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        push_vec(-1, 1, -1);
        push_vec(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f);
    endtask

    initial begin
        int n;
        angle_reg[0] = '0;
        angle_reg[1] = '0;
        angle_reg[2] = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // identity: all angles at reset value
        push_corners();
        wait_drained();

        // full turns act as identity, unused index must not disturb anything
        write_angle(REG_ANGLE_X, 16'd23040);
        write_angle(REG_ANGLE_Y, -16'sd23040);
        write_angle(REG_ANGLE_Z, 16'd23040);
        write_angle(REG_UNUSED, 16'hffff);
        push_corners();
        wait_drained();

        // quarter turns about X and Y, a half turn about Z, saturation at the corners
        write_angle(REG_ANGLE_X, 16'd5760);
        write_angle(REG_ANGLE_Y, -16'sd5760);
        write_angle(REG_ANGLE_Z, 16'd11520);
        push_corners();
        wait_drained();

        // 16-bit extremes, wrapping modulo a full turn
        write_angle(REG_ANGLE_X, 16'h7fff);
        write_angle(REG_ANGLE_Y, 16'h8000);
        write_angle(REG_ANGLE_Z, 16'd2880);
        push_corners();
        wait_drained();

        // random phases, some with back-to-back traffic
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            write_angle(REG_ANGLE_X, pick_angle());
            write_angle(REG_ANGLE_Y, pick_angle());
            write_angle(REG_ANGLE_Z, pick_angle());
            no_gaps = (ph % 3 == 1);
            n = $urandom_range(45, 75);
            for (int i = 0; i < n; i++)
                push_vec(rand_comp(), rand_comp(), rand_comp());
            wait_drained();
        end
        no_gaps = 1'b0;

        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("** euler_xyz_vector_rotate: PASSED **");
        else
            $display("** euler_xyz_vector_rotate: FAILED **");
        $finish;
    end

endmodule
